// File: src/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(WORD_WIDTH);
  localparam int IDX_W      = 2;

  localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(1);

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// File: src/modular_exponentiation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Computes message^exponent mod modulus with one shared modular multiplier.
// Each modular multiplication runs 32 shift-and-add steps between launch and
// hand-back; a beat needs 33 + popcount(exponent) of them, and a zero
// modulus gives a result of zero with no multiplication.
// One beat at a time: start is taken only while busy is low.
// Synchronous reset sets exponent to 0 and modulus to 1 and aborts any beat.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire word_t            message,
  output logic                  done,
  output word_t                 power_result,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire word_t            wr_data
);

  word_t    exponent;
  word_t    modulus;
  mul_req_t req;
  mul_rsp_t rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= WORD_WIDTH'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_EXPONENT: exponent <= wr_data;
        REG_MODULUS:  modulus  <= wr_data;
        default: begin
        end
      endcase
    end
  end

  mexp_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .message      (message),
    .exponent     (exponent),
    .modulus      (modulus),
    .rsp          (rsp),
    .req          (req),
    .busy         (busy),
    .done         (done),
    .power_result (power_result)
  );

  mexp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .modulus (modulus),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// File: src/mexp_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_modmul
// Shared modular multiplier: shift-and-add over the bits of b, most
// significant first, one bit per cycle with conditional subtractions.
// ----------------------------------------------------------------------------
module mexp_modmul
  import mexp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  input  wire word_t    modulus,
  output mul_rsp_t      rsp
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  word_t            acc;
  word_t            a_reg;
  word_t            b_reg;
  logic             done;

  logic [WORD_WIDTH:0] dbl_sum;
  word_t               dbl;
  logic [WORD_WIDTH:0] add_sum;
  word_t               acc_next;

  always_comb begin
    dbl_sum = {1'b0, acc} + {1'b0, acc};
    if (dbl_sum >= {1'b0, modulus}) begin
      dbl = WORD_WIDTH'(dbl_sum - {1'b0, modulus});
    end else begin
      dbl = dbl_sum[WORD_WIDTH-1:0];
    end
    add_sum  = {1'b0, dbl} + {1'b0, a_reg};
    acc_next = dbl;
    if (b_reg[WORD_WIDTH-1]) begin
      if (add_sum >= {1'b0, modulus}) begin
        acc_next = WORD_WIDTH'(add_sum - {1'b0, modulus});
      end else begin
        acc_next = add_sum[WORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(WORD_WIDTH - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= '0;
      a_reg <= req.a;
      b_reg <= req.b;
    end else if (running) begin
      acc   <= acc_next;
      b_reg <= {b_reg[WORD_WIDTH-2:0], 1'b0};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !running)
    else $error("multiplier started while running");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (running && $past(running) && modulus != '0 && $stable(modulus)) |-> acc < modulus)
    else $error("accumulator not reduced");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

`default_nettype wire

// File: src/mexp_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_seq
// Square-and-multiply sequencer driving the shared modular multiplier.
// ----------------------------------------------------------------------------
module mexp_seq
  import mexp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire word_t    message,
  input  wire word_t    exponent,
  input  wire word_t    modulus,
  input  wire mul_rsp_t rsp,
  output mul_req_t      req,
  output logic          busy,
  output logic          done,
  output word_t         power_result
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_SQUARE = 4'b0100,
    ST_MULT   = 4'b1000
  } state_t;

  state_t           state;
  word_t            base;
  logic [CNT_W-1:0] bit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      req.start <= 1'b0;
      bit_idx   <= '0;
    end else begin
      done      <= 1'b0;
      req.start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (modulus == '0) begin
              power_result <= '0;
              done         <= 1'b1;
            end else begin
              req.start <= 1'b1;
              req.a     <= WORD_WIDTH'(1);
              req.b     <= message;
              state     <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (rsp.done) begin
            base      <= rsp.product;
            bit_idx   <= CNT_W'(WORD_WIDTH - 1);
            req.start <= 1'b1;
            req.a     <= (modulus == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
            req.b     <= (modulus == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
            state     <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (rsp.done) begin
            if (exponent[bit_idx]) begin
              req.start <= 1'b1;
              req.a     <= rsp.product;
              req.b     <= base;
              state     <= ST_MULT;
            end else if (bit_idx == '0) begin
              power_result <= rsp.product;
              done         <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              bit_idx   <= bit_idx - 1'b1;
              req.start <= 1'b1;
              req.a     <= rsp.product;
              req.b     <= rsp.product;
            end
          end
        end
        ST_MULT: begin
          if (rsp.done) begin
            if (bit_idx == '0) begin
              power_result <= rsp.product;
              done         <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              bit_idx   <= bit_idx - 1'b1;
              req.start <= 1'b1;
              req.a     <= rsp.product;
              req.b     <= rsp.product;
              state     <= ST_SQUARE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (power_result < modulus) || (modulus == '0 && power_result == '0))
    else $error("result not reduced");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat produced neither work nor result");

  a_idle_no_launch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !start) |=> !req.start)
    else $error("multiplication launched while idle");

endmodule

`default_nettype wire
